[hw/rtl/cbd_pkg.sv]
// ----------------------------------------------------------------------------
// Cartridge bus decoder package
// Shared sizes, codes, word types and state types for the cartridge bus
// decoder and its submodules.
// ----------------------------------------------------------------------------
package cbd_pkg;

  // Save RAM geometry.
  localparam int SRAM_BYTES = 32768;
  localparam int SRAM_AW    = $clog2(SRAM_BYTES);

  // ROM index geometry: linear ROM addresses from either map fit in 22 bits.
  localparam int ROM_ADDR_BITS = 24;
  localparam int ROM_IDX_W     = 24;
  localparam int ROM_LIN_W     = 22;
  localparam int ROM_SIZE_W    = 25;
  localparam logic [ROM_IDX_W-1:0] ROM_IDX_MASK =
    ROM_IDX_W'((64'd1 << ROM_ADDR_BITS) - 64'd1);

  // Configuration port.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_MAP_MODE  = 2'd0;
  localparam logic [1:0] REG_ROM_SIZE  = 2'd1;
  localparam logic [1:0] REG_SRAM_SIZE = 2'd2;

  // Map modes.
  localparam logic [1:0] MAP_NONE  = 2'd0;
  localparam logic [1:0] MAP_LOROM = 2'd1;
  localparam logic [1:0] MAP_HIROM = 2'd2;

  // Access commands.
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Window bounds.
  localparam logic [7:0]  LO_SRAM_BANK_LO  = 8'h70;
  localparam logic [7:0]  LO_SRAM_BANK_HI  = 8'h7e;
  localparam logic [7:0]  LO_SRAM_BANK_TOP = 8'hf0;
  localparam logic [2:0]  HI_SRAM_PAGE     = 3'b011;

  // Result targets.
  typedef enum logic [1:0] {
    TGT_ROM     = 2'd0,
    TGT_SRAM    = 2'd1,
    TGT_OPEN    = 2'd2,
    TGT_IGNORED = 2'd3
  } target_t;

  // One bus access.
  typedef struct packed {
    logic       cmd;
    logic [7:0] bank;
    logic [15:0] addr;
    logic [7:0] wdata;
    logic [7:0] open_bus;
  } req_t;

  // One decoded result.
  typedef struct packed {
    logic [7:0]           rdata;
    target_t              target;
    logic [ROM_IDX_W-1:0] rom_index;
  } rsp_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [1:0]            map_mode;
    logic [ROM_SIZE_W-1:0] rom_size;
    logic                  sram_en;
    logic [SRAM_AW-1:0]    sram_mask;
    logic                  load;
  } cfg_t;

  // Main sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RAM_RD,
    ST_FOLD,
    ST_EMIT
  } seq_state_t;

  // ROM fold unit states.
  typedef enum logic [1:0] {
    FD_IDLE,
    FD_RUN,
    FD_SUM
  } fold_state_t;

endpackage

[hw/rtl/cbd_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read/write port with a registered read.
// ----------------------------------------------------------------------------
module cbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read through a register.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hw/rtl/cbd_regs.sv]
// ----------------------------------------------------------------------------
// Cartridge bus decoder configuration registers
// APB-style register file for map mode, ROM size and save RAM size. Works
// out the effective save RAM mask when the size is written.
// ----------------------------------------------------------------------------
module cbd_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cbd_pkg::PADDR_W-1:0] paddr,
  input  logic [cbd_pkg::PDATA_W-1:0] pwdata,
  output logic [cbd_pkg::PDATA_W-1:0] prdata,
  output cbd_pkg::cfg_t               cfg
);

  logic [1:0]                     map_mode;
  logic [cbd_pkg::ROM_SIZE_W-1:0] rom_size;
  logic [15:0]                    sram_size;
  logic                           sram_en;
  logic [cbd_pkg::SRAM_AW-1:0]    sram_mask;
  logic                           wr_strobe;
  logic [1:0]                     reg_sel;
  logic [cbd_pkg::SRAM_AW:0]      sram_cfg;

  // Largest power of two not above the clamped size, as an enable and a mask.
  function automatic logic [cbd_pkg::SRAM_AW:0] sram_cfg_f(input logic [15:0] sz);
    logic [31:0] lim;
    logic [31:0] smear;
    lim = 32'(sz);
    if (lim > 32'(cbd_pkg::SRAM_BYTES)) begin
      lim = 32'(cbd_pkg::SRAM_BYTES);
    end
    smear = lim | (lim >> 1);
    smear = smear | (smear >> 2);
    smear = smear | (smear >> 4);
    smear = smear | (smear >> 8);
    smear = smear | (smear >> 16);
    return {(lim != 32'd0), cbd_pkg::SRAM_AW'(smear >> 1)};
  endfunction

  assign wr_strobe = psel & penable & pwrite;
  assign reg_sel   = paddr[3:2];
  assign sram_cfg  = sram_cfg_f(pwdata[15:0]);

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      map_mode  <= cbd_pkg::MAP_NONE;
      rom_size  <= '0;
      sram_size <= '0;
      sram_en   <= 1'b0;
      sram_mask <= '0;
    end else if (wr_strobe) begin
      unique case (reg_sel)
        cbd_pkg::REG_MAP_MODE:  map_mode <= pwdata[1:0];
        cbd_pkg::REG_ROM_SIZE:  rom_size <= pwdata[cbd_pkg::ROM_SIZE_W-1:0];
        cbd_pkg::REG_SRAM_SIZE: begin
          sram_size <= pwdata[15:0];
          sram_en   <= sram_cfg[cbd_pkg::SRAM_AW];
          sram_mask <= sram_cfg[cbd_pkg::SRAM_AW-1:0];
        end
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (reg_sel)
      cbd_pkg::REG_MAP_MODE:  prdata = cbd_pkg::PDATA_W'(map_mode);
      cbd_pkg::REG_ROM_SIZE:  prdata = cbd_pkg::PDATA_W'(rom_size);
      cbd_pkg::REG_SRAM_SIZE: prdata = cbd_pkg::PDATA_W'(sram_size);
      default:                prdata = '0;
    endcase
  end

  // A save RAM size write acts as a cartridge load and starts a clear.
  always_comb begin
    cfg.map_mode  = map_mode;
    cfg.rom_size  = rom_size;
    cfg.sram_en   = sram_en;
    cfg.sram_mask = sram_mask;
    cfg.load      = wr_strobe && (reg_sel == cbd_pkg::REG_SRAM_SIZE);
  end

endmodule

[hw/rtl/cbd_fold.sv]
// ----------------------------------------------------------------------------
// ROM index fold unit
// Folds a linear ROM address into a ROM image of any size, one address bit
// per cycle: a ROM that is not a power of two mirrors its top part back onto
// the last power-of-two chunk.
// ----------------------------------------------------------------------------
module cbd_fold (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [cbd_pkg::ROM_LIN_W-1:0]  lin,
  input  logic [cbd_pkg::ROM_SIZE_W-1:0] size,
  output logic                          done,
  output logic [cbd_pkg::ROM_IDX_W-1:0]  idx
);

  localparam int PAD_W = cbd_pkg::ROM_SIZE_W - cbd_pkg::ROM_LIN_W;

  cbd_pkg::fold_state_t state, state_next;

  logic [cbd_pkg::ROM_LIN_W-1:0]  a;
  logic [cbd_pkg::ROM_LIN_W-1:0]  base;
  logic [cbd_pkg::ROM_LIN_W-1:0]  top;
  logic [cbd_pkg::ROM_SIZE_W-1:0] sz;
  logic                          size_zero;
  logic                          finish;
  logic [cbd_pkg::ROM_SIZE_W-1:0] top_ext;

  assign top_ext = {{PAD_W{1'b0}}, top};
  assign finish  = size_zero || ({{PAD_W{1'b0}}, a} < sz);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbd_pkg::FD_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == cbd_pkg::FD_SUM);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      cbd_pkg::FD_IDLE: if (start)  state_next = cbd_pkg::FD_RUN;
      cbd_pkg::FD_RUN:  if (finish) state_next = cbd_pkg::FD_SUM;
      cbd_pkg::FD_SUM:  state_next = cbd_pkg::FD_IDLE;
      default:          state_next = cbd_pkg::FD_IDLE;
    endcase
  end

  // One step per cycle: skip a clear bit of the address, or strip a set one.
  always_ff @(posedge clk) begin
    if (start) begin
      a         <= lin;
      sz        <= size;
      base      <= '0;
      top       <= {1'b1, {(cbd_pkg::ROM_LIN_W-1){1'b0}}};
      size_zero <= (size == '0);
    end else if (state == cbd_pkg::FD_RUN && !finish) begin
      if ((a & top) == '0) begin
        top <= top >> 1;
      end else begin
        a <= a & ~top;
        if (sz > top_ext) begin
          sz   <= sz - top_ext;
          base <= base | top;
        end
      end
    end
    if (state == cbd_pkg::FD_SUM) begin
      if (size_zero) begin
        idx <= '0;
      end else begin
        idx <= (cbd_pkg::ROM_IDX_W'(base) + cbd_pkg::ROM_IDX_W'(a)) & cbd_pkg::ROM_IDX_MASK;
      end
    end
  end

endmodule

[hw/rtl/cartridge_bus_decoder.sv]
// ----------------------------------------------------------------------------
// Cartridge bus decoder
// Decodes one bus access under the LoROM or HiROM map. Save RAM accesses go
// to an internal save RAM, ROM reads return a folded ROM index, and other
// reads return the open-bus byte.
// ----------------------------------------------------------------------------
//
//   channel   signals                         direction  word
//   req       req_valid, req_ready, req       in         req_t bus access
//   rsp       rsp_valid, rsp_ready, rsp       out        rsp_t decoded result
//   apb       psel, penable, pwrite, paddr,   in/out     32-bit register
//             pwdata, prdata, pready
//
// Save RAM reads pass the decode, RAM read and emit states; ROM reads wait in
// the fold state between decode and emit for the fold unit, which spends one
// cycle per address bit it skips or strips; all other accesses go from decode
// to emit. Reset and every save RAM size write start a clearing pass through
// all SRAM_BYTES (32768) save RAM bytes; req_ready stays low meanwhile.
// One access is in work at a time. A finished word waits in the output
// register while the next access is accepted.
// ----------------------------------------------------------------------------
module cartridge_bus_decoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  cbd_pkg::req_t               req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output cbd_pkg::rsp_t               rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cbd_pkg::PADDR_W-1:0] paddr,
  input  logic [cbd_pkg::PDATA_W-1:0] pwdata,
  output logic [cbd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  cbd_pkg::cfg_t       cfg;
  cbd_pkg::seq_state_t state, state_next;
  cbd_pkg::req_t       item;
  cbd_pkg::rsp_t       res, res_next;

  logic                          clear_busy;
  logic [cbd_pkg::SRAM_AW-1:0]   clear_cnt;
  logic                          ram_we;
  logic [cbd_pkg::SRAM_AW-1:0]   ram_addr;
  logic [7:0]                    ram_wdata;
  logic [7:0]                    ram_rdata;
  logic                          item_ram_we;
  logic                          fold_start;
  logic                          fold_done;
  logic [cbd_pkg::ROM_IDX_W-1:0] fold_idx;
  logic                          emit;

  // Decode results.
  logic                          in_sram;
  logic                          in_rom;
  logic [18:0]                   sram_lin;
  logic [cbd_pkg::SRAM_AW-1:0]   sidx;
  logic [cbd_pkg::ROM_LIN_W-1:0] rlin;

  assign pready    = 1'b1;
  assign req_ready = (state == cbd_pkg::ST_IDLE) && !clear_busy;

  cbd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  cbd_fold u_fold (
    .clk   (clk),
    .rst   (rst),
    .start (fold_start),
    .lin   (rlin),
    .size  (cfg.rom_size),
    .done  (fold_done),
    .idx   (fold_idx)
  );

  // Save RAM: the clearing pass owns the port while it runs.
  assign ram_we    = clear_busy | item_ram_we;
  assign ram_addr  = clear_busy ? clear_cnt : sidx;
  assign ram_wdata = clear_busy ? 8'h00 : item.wdata;

  cbd_ram #(
    .WIDTH (8),
    .DEPTH (cbd_pkg::SRAM_BYTES)
  ) u_save_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Clearing pass after reset and on every cartridge load.
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clear_cnt  <= '0;
    end else if (cfg.load) begin
      clear_busy <= 1'b1;
      clear_cnt  <= '0;
    end else if (clear_busy) begin
      clear_cnt <= clear_cnt + 1'b1;
      if (clear_cnt == cbd_pkg::SRAM_AW'(cbd_pkg::SRAM_BYTES - 1)) begin
        clear_busy <= 1'b0;
      end
    end
  end

  // Address decode of the held access under the current map.
  always_comb begin
    in_sram  = 1'b0;
    in_rom   = 1'b0;
    sram_lin = '0;
    rlin     = '0;
    unique case (cfg.map_mode)
      cbd_pkg::MAP_LOROM: begin
        sram_lin = {item.bank[3:0], item.addr[14:0]};
        rlin     = {item.bank[6:0], item.addr[14:0]};
        if (((item.bank >= cbd_pkg::LO_SRAM_BANK_LO && item.bank < cbd_pkg::LO_SRAM_BANK_HI)
             || item.bank >= cbd_pkg::LO_SRAM_BANK_TOP)
            && !item.addr[15] && cfg.sram_en) begin
          in_sram = 1'b1;
        end else begin
          in_rom = item.addr[15] | item.bank[6];
        end
      end
      cbd_pkg::MAP_HIROM: begin
        sram_lin = {item.bank[5:0], item.addr[12:0]};
        rlin     = {item.bank[5:0], item.addr};
        if (!item.bank[6] && item.addr[15:13] == cbd_pkg::HI_SRAM_PAGE && cfg.sram_en) begin
          in_sram = 1'b1;
        end else begin
          in_rom = item.addr[15] | item.bank[6];
        end
      end
      default: ;
    endcase
  end

  assign sidx = sram_lin[cbd_pkg::SRAM_AW-1:0] & cfg.sram_mask;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and per-state actions.
  always_comb begin
    state_next  = state;
    res_next    = res;
    item_ram_we = 1'b0;
    fold_start  = 1'b0;
    emit        = 1'b0;
    unique case (state)
      cbd_pkg::ST_IDLE: begin
        if (req_valid && req_ready) begin
          state_next = cbd_pkg::ST_DECODE;
        end
      end
      cbd_pkg::ST_DECODE: begin
        res_next.rdata     = 8'h00;
        res_next.rom_index = '0;
        if (item.cmd == cbd_pkg::CMD_WRITE) begin
          if (in_sram) begin
            item_ram_we     = 1'b1;
            res_next.target = cbd_pkg::TGT_SRAM;
          end else begin
            res_next.target = cbd_pkg::TGT_IGNORED;
          end
          state_next = cbd_pkg::ST_EMIT;
        end else if (in_sram) begin
          res_next.target = cbd_pkg::TGT_SRAM;
          state_next      = cbd_pkg::ST_RAM_RD;
        end else if (in_rom) begin
          res_next.target = cbd_pkg::TGT_ROM;
          fold_start      = 1'b1;
          state_next      = cbd_pkg::ST_FOLD;
        end else begin
          res_next.rdata  = item.open_bus;
          res_next.target = cbd_pkg::TGT_OPEN;
          state_next      = cbd_pkg::ST_EMIT;
        end
      end
      cbd_pkg::ST_RAM_RD: begin
        res_next.rdata = ram_rdata;
        state_next     = cbd_pkg::ST_EMIT;
      end
      cbd_pkg::ST_FOLD: begin
        if (fold_done) begin
          res_next.rom_index = fold_idx;
          state_next         = cbd_pkg::ST_EMIT;
        end
      end
      cbd_pkg::ST_EMIT: begin
        if (!rsp_valid || rsp_ready) begin
          emit       = 1'b1;
          state_next = cbd_pkg::ST_IDLE;
        end
      end
      default: state_next = cbd_pkg::ST_IDLE;
    endcase
  end

  // Held access and result under construction.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= req;
    end
    res <= res_next;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp <= res;
    end
  end

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// Cartridge bus decoder testbench
// Sends bus accesses under each map mode and several ROM and save RAM sizes.
// A scoreboard keeps its own copy of the registers and the save RAM, works
// out each decoded word as an access is accepted, and checks every result
// word in order. Both handshake sides idle at random outside the steady stretch.
// ----------------------------------------------------------------------------
class access_checker;
  logic [1:0]    map_mode;
  logic [24:0]   rom_size;
  logic [15:0]   sram_size;
  logic [7:0]    save_ram [cbd_pkg::SRAM_BYTES];
  cbd_pkg::rsp_t pending_rsp [$];
  int            mismatches;

  function new();
    map_mode   = cbd_pkg::MAP_NONE;
    rom_size   = '0;
    sram_size  = '0;
    mismatches = 0;
    foreach (save_ram[i]) save_ram[i] = 8'h00;
  endfunction

  // A save RAM size write is a cartridge load and wipes the save RAM.
  function void write_reg(logic [1:0] idx, logic [31:0] value);
    if (idx == cbd_pkg::REG_MAP_MODE) begin
      map_mode = value[1:0];
    end else if (idx == cbd_pkg::REG_ROM_SIZE) begin
      rom_size = value[24:0];
    end else if (idx == cbd_pkg::REG_SRAM_SIZE) begin
      sram_size = value[15:0];
      foreach (save_ram[i]) save_ram[i] = 8'h00;
    end
  endfunction

  // Largest power of two not above the clamped save RAM size, or zero.
  function logic [31:0] sram_window();
    logic [31:0] lim;
    logic [31:0] p;
    lim = (32'(sram_size) > 32'(cbd_pkg::SRAM_BYTES)) ? 32'(cbd_pkg::SRAM_BYTES)
                                                      : 32'(sram_size);
    if (lim == 0) return 0;
    p = 1;
    while ((p << 1) <= lim) p <<= 1;
    return p;
  endfunction

  // Fold a linear ROM address into a ROM of any size: the part above the
  // last power-of-two chunk mirrors down one address bit at a time.
  function logic [31:0] fold_rom(logic [31:0] a, logic [31:0] size);
    logic [31:0] base;
    logic [31:0] top;
    logic [31:0] sz;
    logic [31:0] x;
    base = 0;
    top  = 32'h8000_0000;
    sz   = size;
    x    = a;
    if (sz == 0) return 0;
    if ((sz & (sz - 1)) == 0) return x & (sz - 1);
    while (x >= sz) begin
      while ((x & top) == 0) top >>= 1;
      x -= top;
      if (sz > top) begin
        sz   -= top;
        base += top;
      end
    end
    return base + x;
  endfunction

  // Decode one accepted access and queue the word it must produce.
  function void note_access(cbd_pkg::req_t a);
    logic [31:0]   ssz;
    logic [31:0]   sidx;
    logic [31:0]   rlin;
    logic [7:0]    b;
    logic          in_sram;
    logic          in_rom;
    cbd_pkg::rsp_t w;
    ssz       = sram_window();
    sidx      = 0;
    rlin      = 0;
    b         = a.bank & 8'h7f;
    in_sram   = 1'b0;
    in_rom    = 1'b0;
    w.rdata     = 8'h00;
    w.rom_index = '0;
    if (map_mode == cbd_pkg::MAP_LOROM) begin
      if (((a.bank >= cbd_pkg::LO_SRAM_BANK_LO && a.bank < cbd_pkg::LO_SRAM_BANK_HI) ||
           a.bank >= cbd_pkg::LO_SRAM_BANK_TOP) && !a.addr[15] && ssz > 0) begin
        in_sram = 1'b1;
        sidx    = ((32'(a.bank[3:0]) << 15) | 32'(a.addr)) & (ssz - 1);
      end else if (a.addr[15] || b >= 8'h40) begin
        in_rom = 1'b1;
        rlin   = (32'(b) << 15) | 32'(a.addr[14:0]);
      end
    end else if (map_mode == cbd_pkg::MAP_HIROM) begin
      if (b < 8'h40 && a.addr[15:13] == cbd_pkg::HI_SRAM_PAGE && ssz > 0) begin
        in_sram = 1'b1;
        sidx    = ((32'(b[5:0]) << 13) | 32'(a.addr[12:0])) & (ssz - 1);
      end else if (a.addr[15] || b >= 8'h40) begin
        in_rom = 1'b1;
        rlin   = (32'(b[5:0]) << 16) | 32'(a.addr);
      end
    end

    if (a.cmd == cbd_pkg::CMD_WRITE) begin
      if (in_sram) begin
        save_ram[sidx[14:0]] = a.wdata;
        w.target = cbd_pkg::TGT_SRAM;
      end else begin
        w.target = cbd_pkg::TGT_IGNORED;
      end
    end else if (in_sram) begin
      w.rdata  = save_ram[sidx[14:0]];
      w.target = cbd_pkg::TGT_SRAM;
    end else if (in_rom) begin
      w.rom_index = cbd_pkg::ROM_IDX_W'(fold_rom(rlin, 32'(rom_size)) &
                                        32'(cbd_pkg::ROM_IDX_MASK));
      w.target    = cbd_pkg::TGT_ROM;
    end else begin
      w.rdata  = a.open_bus;
      w.target = cbd_pkg::TGT_OPEN;
    end
    pending_rsp.push_back(w);
  endfunction

  // Compare a result word with the oldest word still owed.
  function void check_result(cbd_pkg::rsp_t r);
    cbd_pkg::rsp_t w;
    if (pending_rsp.size() == 0) begin
      $error("unexpected result word: rdata %0h target %0d rom_index %0h",
             r.rdata, r.target, r.rom_index);
      mismatches++;
      return;
    end
    w = pending_rsp.pop_front();
    if (r.rdata !== w.rdata) begin
      $error("rdata: expected %0h, actual %0h", w.rdata, r.rdata);
      mismatches++;
    end
    if (r.target !== w.target) begin
      $error("target: expected %0d, actual %0d", w.target, r.target);
      mismatches++;
    end
    if (r.rom_index !== w.rom_index) begin
      $error("rom_index: expected %0h, actual %0h", w.rom_index, r.rom_index);
      mismatches++;
    end
  endfunction

  function int owed();
    return pending_rsp.size();
  endfunction
endclass

module tb;
  localparam logic [1:0] MAP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 120000;
  localparam int SETTLE_CYCLES = 64;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          req_valid = 1'b0;
  logic                          req_ready;
  cbd_pkg::req_t                 req = '0;
  logic                          rsp_valid;
  logic                          rsp_ready = 1'b0;
  cbd_pkg::rsp_t                 rsp;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [cbd_pkg::PADDR_W-1:0]   paddr = '0;
  logic [cbd_pkg::PDATA_W-1:0]   pwdata = '0;
  logic [cbd_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;

  access_checker sb = new();
  bit            steady = 1'b0;
  int            quiet_cycles = 0;

  cartridge_bus_decoder dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The result side stalls at random except during the steady stretch.
  always @(posedge clk) begin
    rsp_ready <= steady || ($urandom_range(0, 99) >= 22);
  end

  // Sample both handshakes and watch for a hung block.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) sb.note_access(req);
      if (rsp_valid && rsp_ready) sb.check_result(rsp);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Setup cycle, then access cycle until pready.
  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one access word, with random idle cycles in front of it outside the steady stretch.
  task automatic send(cbd_pkg::req_t a);
    while (!steady && $urandom_range(0, 99) < 22) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= a;
    do @(posedge clk); while (!req_ready);
  endtask

  // Let every owed word arrive, then let the block settle. The first edge
  // makes sure the last accepted access has been noted.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_cart(logic [1:0] mode, logic [31:0] rom, logic [31:0] sram);
    drain();
    reg_write(cbd_pkg::REG_MAP_MODE, 32'(mode));
    reg_write(cbd_pkg::REG_ROM_SIZE, rom);
    reg_write(cbd_pkg::REG_SRAM_SIZE, sram);
  endtask

  function automatic cbd_pkg::req_t mk(logic cmd, logic [7:0] bank, logic [15:0] addr,
                                       logic [7:0] wdata, logic [7:0] obus);
    cbd_pkg::req_t a;
    a.cmd      = cmd;
    a.bank     = bank;
    a.addr     = addr;
    a.wdata    = wdata;
    a.open_bus = obus;
    return a;
  endfunction

  // Random access aimed mostly at the save RAM and ROM windows of the map.
  function automatic cbd_pkg::req_t random_access(logic [1:0] mode);
    cbd_pkg::req_t a;
    int            kind;
    kind       = $urandom_range(0, 9);
    a.cmd      = 1'($urandom_range(0, 1));
    a.bank     = 8'($urandom_range(0, 255));
    a.addr     = 16'($urandom_range(0, 65535));
    a.wdata    = 8'($urandom_range(0, 255));
    a.open_bus = 8'($urandom_range(0, 255));
    if (kind < 4) begin
      if (mode == cbd_pkg::MAP_HIROM) begin
        a.bank = {1'($urandom_range(0, 1)), 1'b0, 6'($urandom_range(0, 63))};
        a.addr = 16'($urandom_range(16'h6000, 16'h7fff));
      end else begin
        a.bank = $urandom_range(0, 1) ? 8'($urandom_range(8'h70, 8'h7d))
                                      : 8'($urandom_range(8'hf0, 8'hff));
        a.addr = 16'($urandom_range(0, 16'h7fff));
      end
    end else if (kind < 7) begin
      a.cmd  = ($urandom_range(0, 4) == 0) ? cbd_pkg::CMD_WRITE : cbd_pkg::CMD_READ;
      a.addr = 16'($urandom_range(16'h8000, 16'hffff));
    end
    return a;
  endfunction

  task automatic random_run(logic [1:0] mode, int n);
    for (int i = 0; i < n; i++) send(random_access(mode));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // LoROM, 1 MB ROM, 2 KB save RAM: window edges and mirrored save RAM.
    load_cart(cbd_pkg::MAP_LOROM, 32'h10_0000, 32'd2048);
    send(mk(cbd_pkg::CMD_WRITE, 8'h70, 16'h0000, 8'hff, 8'h00));
    send(mk(cbd_pkg::CMD_READ,  8'h70, 16'h0000, 8'h00, 8'h00));
    send(mk(cbd_pkg::CMD_WRITE, 8'hff, 16'h7fff, 8'ha5, 8'hff));
    send(mk(cbd_pkg::CMD_READ,  8'hf7, 16'h07ff, 8'h00, 8'hff));
    send(mk(cbd_pkg::CMD_READ,  8'h7d, 16'h1234, 8'h00, 8'h33));
    send(mk(cbd_pkg::CMD_READ,  8'h7e, 16'h0000, 8'h00, 8'h5a));
    send(mk(cbd_pkg::CMD_READ,  8'h00, 16'h0000, 8'h00, 8'hff));
    send(mk(cbd_pkg::CMD_READ,  8'h00, 16'h8000, 8'h00, 8'h00));
    send(mk(cbd_pkg::CMD_READ,  8'hff, 16'hffff, 8'hff, 8'hff));
    send(mk(cbd_pkg::CMD_WRITE, 8'h80, 16'h8000, 8'h12, 8'h00));
    send(mk(cbd_pkg::CMD_READ,  8'hef, 16'h0000, 8'h00, 8'h00));
    send(mk(cbd_pkg::CMD_READ,  8'h6f, 16'h7fff, 8'h00, 8'h00));
    random_run(cbd_pkg::MAP_LOROM, 200);

    // HiROM, 3 MB ROM that folds, 8 KB save RAM.
    load_cart(cbd_pkg::MAP_HIROM, 32'h30_0000, 32'd8192);
    send(mk(cbd_pkg::CMD_WRITE, 8'h20, 16'h6000, 8'h3c, 8'h00));
    send(mk(cbd_pkg::CMD_READ,  8'ha0, 16'h6000, 8'h00, 8'h00));
    send(mk(cbd_pkg::CMD_READ,  8'hbf, 16'h7fff, 8'h00, 8'h00));
    send(mk(cbd_pkg::CMD_READ,  8'h3f, 16'h5fff, 8'h00, 8'h81));
    send(mk(cbd_pkg::CMD_READ,  8'h40, 16'h0000, 8'h00, 8'h00));
    send(mk(cbd_pkg::CMD_READ,  8'hff, 16'hffff, 8'h00, 8'h00));
    send(mk(cbd_pkg::CMD_READ,  8'h00, 16'h8000, 8'h00, 8'h00));
    send(mk(cbd_pkg::CMD_WRITE, 8'h00, 16'h8000, 8'h77, 8'h00));
    send(mk(cbd_pkg::CMD_WRITE, 8'hc0, 16'h6000, 8'h99, 8'h00));
    random_run(cbd_pkg::MAP_HIROM, 200);

    // Full-size save RAM with no idling on either side.
    load_cart(cbd_pkg::MAP_LOROM, 32'h18_0000, 32'd32768);
    steady = 1'b1;
    random_run(cbd_pkg::MAP_LOROM, 150);
    drain();
    steady = 1'b0;

    // Largest ROM size and a save RAM size above the store, clamped.
    load_cart(cbd_pkg::MAP_HIROM, 32'h1ff_ffff, 32'd65535);
    random_run(cbd_pkg::MAP_HIROM, 150);

    // No ROM and no save RAM: the save RAM window decodes as ROM or open bus.
    load_cart(cbd_pkg::MAP_LOROM, 32'd0, 32'd0);
    random_run(cbd_pkg::MAP_LOROM, 100);

    // No cartridge: reads give open bus, writes are ignored.
    load_cart(cbd_pkg::MAP_NONE, $urandom, 32'd1);
    send(mk(cbd_pkg::CMD_READ,  8'h00, 16'h8000, 8'h00, 8'hc3));
    send(mk(cbd_pkg::CMD_WRITE, 8'h70, 16'h0000, 8'h11, 8'h00));
    random_run(cbd_pkg::MAP_LOROM, 80);

    // Unused map mode behaves as no cartridge.
    load_cart(MAP_UNUSED, $urandom, $urandom_range(0, 65535));
    random_run(cbd_pkg::MAP_HIROM, 60);

    // One-byte ROM and a save RAM size that is not a power of two.
    load_cart(cbd_pkg::MAP_HIROM, 32'd1, 32'd3000);
    random_run(cbd_pkg::MAP_HIROM, 100);

    // 16 MB ROM with a random power-of-two save RAM.
    load_cart(cbd_pkg::MAP_LOROM, 32'h100_0000, 32'd1 << $urandom_range(0, 15));
    random_run(cbd_pkg::MAP_LOROM, 150);

    // Random ROM and save RAM sizes.
    load_cart(cbd_pkg::MAP_HIROM, $urandom_range(1, 32'h40_0000), $urandom_range(0, 65535));
    random_run(cbd_pkg::MAP_HIROM, 160);

    drain();
    if (sb.mismatches == 0 && sb.owed() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

[sim.f]
hw/rtl/cbd_pkg.sv
hw/rtl/cbd_ram.sv
hw/rtl/cbd_regs.sv
hw/rtl/cbd_fold.sv
hw/rtl/cartridge_bus_decoder.sv
verif/tb.sv
